// File: rtl/flux_interval_to_mfm_word_core_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the flux interval to MFM word core
// Concurrent checks that sample on clk and are held off during reset.
// ---------------------------------------------------------------------------
`ifndef FLUX_INTERVAL_TO_MFM_WORD_CORE_ASSERT_SVH
`define FLUX_INTERVAL_TO_MFM_WORD_CORE_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication.
`define FIMW_ASSERT_IMPLY(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error("fimw assertion failed");

// Next-cycle implication.
`define FIMW_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error("fimw assertion failed");

`else

`define FIMW_ASSERT_IMPLY(label, ante, cons)
`define FIMW_ASSERT_NEXT(label, ante, cons)

`endif

`endif

// File: rtl/fimw_pkg.sv
// ---------------------------------------------------------------------------
// fimw_pkg
// Types and constants shared by the flux interval to MFM word decoder.
// ---------------------------------------------------------------------------
package fimw_pkg;

	localparam int FLUX_W    = 16;
	localparam int PEND_W    = 20;
	localparam int UNITS_W   = 12;
	localparam int WORD_W    = 16;
	localparam int BYTE_W    = 8;
	localparam int TOL_W     = 6;
	localparam int SHIFTS_W  = 4;
	localparam int CFG_IDX_W = 1;

	// Register indexes of the configuration port.
	localparam logic [CFG_IDX_W-1:0] CFG_TOL  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_SYNC = 1'b1;

	localparam logic [TOL_W-1:0]  TOL_RESET  = 6'd8;
	localparam logic [WORD_W-1:0] SYNC_RESET = 16'h4489;

	localparam logic [FLUX_W-1:0] OVERFLOW_UNITS = 16'hFFFF;
	localparam logic [PEND_W-1:0] PENDING_MAX    = 20'hFFFFF;

	// Any total of at least 64 us already gives 32 cells, which is above
	// every allowed cell limit, so the quantizer only ever sees 12 bits.
	localparam logic [UNITS_W-1:0] CLAMP_UNITS = 12'd2560;

	// x / 40 = (x >> 3) / 5, and (y * 205) >> 10 is exact for y < 1024.
	localparam logic [7:0] RECIP_5 = 8'd205;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_QUANT,
		ST_SHIFT,
		ST_DRAIN
	} fimw_state_t;

	typedef struct packed {
		logic                done;
		logic [SHIFTS_W-1:0] shifts;
	} quant_res_t;

	function automatic logic [BYTE_W-1:0] pick_data(input logic [WORD_W-1:0] w);
		logic [BYTE_W-1:0] r;
		for (int i = 0; i < BYTE_W; i++) begin
			r[i] = w[2*i];
		end
		return r;
	endfunction

	function automatic logic [BYTE_W-1:0] pick_clock(input logic [WORD_W-1:0] w);
		logic [BYTE_W-1:0] r;
		for (int i = 0; i < BYTE_W; i++) begin
			r[i] = w[2*i+1];
		end
		return r;
	endfunction

endpackage

// File: rtl/fimw_in_if.sv
// ---------------------------------------------------------------------------
// fimw_in_if
// Valid/ready channel that carries one flux interval per item.
// ---------------------------------------------------------------------------
interface fimw_in_if import fimw_pkg::*;;
	logic              valid;
	logic              ready;
	logic [FLUX_W-1:0] flux_interval;

	modport source(output valid, output flux_interval, input ready);
	modport sink(input valid, input flux_interval, output ready);
endinterface

// File: rtl/fimw_out_if.sv
// ---------------------------------------------------------------------------
// fimw_out_if
// Valid/ready channel that carries one decoded MFM word per item.
// ---------------------------------------------------------------------------
interface fimw_out_if import fimw_pkg::*;;
	logic              valid;
	logic              ready;
	logic [WORD_W-1:0] mfm_word;
	logic [BYTE_W-1:0] data_byte;
	logic [BYTE_W-1:0] clock_byte;
	logic              synced;
	logic              last;

	modport source(output valid, output mfm_word, output data_byte, output clock_byte,
		output synced, output last, input ready);
	modport sink(input valid, input mfm_word, input data_byte, input clock_byte,
		input synced, input last, output ready);
endinterface

// File: rtl/fimw_quant.sv
// ---------------------------------------------------------------------------
// fimw_quant
// Two-stage quantizer: flux units to microseconds, then to a bitcell count.
// ---------------------------------------------------------------------------
module fimw_quant import fimw_pkg::*; #(
	parameter int MAX_SHIFTS = 8
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [UNITS_W-1:0] units,
	input  logic [TOL_W-1:0]   window_tolerance,
	output quant_res_t         res
);

	logic                v_s1;
	logic [16:0]         prod_s1;
	logic [UNITS_W-1:0]  units_s1;
	logic                v_s2;
	logic [SHIFTS_W-1:0] shifts_s2;

	logic [6:0]         quot;
	logic [6:0]         quot_inc;
	logic [6:0]         ref_us;
	logic [UNITS_W:0]   ref_scaled;
	logic [UNITS_W:0]   lo_sum;
	logic [UNITS_W:0]   hi_sum;
	logic [6:0]         q_us;
	logic [5:0]         half;
	logic [SHIFTS_W-1:0] shifts_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= start;
			v_s2 <= v_s1;
		end
	end

	// Stage one: the divide by forty as a reciprocal multiplication.
	always_ff @(posedge clk) begin
		if (start) begin
			prod_s1  <= 17'(units[UNITS_W-1:3]) * 17'(RECIP_5);
			units_s1 <= units;
		end
	end

	// Stage two: even reference, tolerance window and cell limit.
	always_comb begin
		quot       = prod_s1[16:10];
		quot_inc   = quot + 7'd1;
		ref_us     = {quot_inc[6:1], 1'b0};
		ref_scaled = (13'(ref_us) << 5) + (13'(ref_us) << 3);
		lo_sum     = 13'(units_s1) + 13'(window_tolerance);
		hi_sum     = ref_scaled + 13'(window_tolerance);
		if (lo_sum < ref_scaled) begin
			q_us = ref_us - 7'd1;
		end else if (13'(units_s1) > hi_sum) begin
			q_us = ref_us + 7'd1;
		end else begin
			q_us = ref_us;
		end
		half = q_us[6:1];
		if (half > 6'(MAX_SHIFTS)) begin
			shifts_d = SHIFTS_W'(MAX_SHIFTS);
		end else begin
			shifts_d = half[SHIFTS_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (v_s1) begin
			shifts_s2 <= shifts_d;
		end
	end

	assign res.done   = v_s2;
	assign res.shifts = shifts_s2;

endmodule

// File: rtl/flux_interval_to_mfm_word_core.sv
// ---------------------------------------------------------------------------
// flux_interval_to_mfm_word_core
// Turns flux reversal intervals into MFM words, realigning on an address mark.
// ---------------------------------------------------------------------------
//
//   channel    direction  handshake     payload
//   flux_in    sink       valid/ready   flux_interval[15:0]
//   word_out   source     valid/ready   mfm_word, data_byte, clock_byte, synced, last
//   cfg_*      sink       write enable  cfg_index selects register, cfg_wdata[15:0]
//
// A zero interval is absorbed in its acceptance cycle. Any other interval is
// accepted, passes the quantizer pipeline and then shifts its bitcells in turn
// (up to MAX_SHIFTS), before up to two words drain, one per cycle while
// word_out is ready. The single bitcell shifter sets the rate.
// Reset clears the decoder state and restores the default registers; a stalled
// word_out holds its word, and a new interval is taken while it waits.
// ---------------------------------------------------------------------------
`include "flux_interval_to_mfm_word_core_assert.svh"

module flux_interval_to_mfm_word_core import fimw_pkg::*; #(
	parameter int MAX_SHIFTS = 8
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [WORD_W-1:0]    cfg_wdata,
	fimw_in_if.sink              flux_in,
	fimw_out_if.source           word_out
);

	// Configuration registers.
	logic [TOL_W-1:0]  tol_q;
	logic [WORD_W-1:0] sync_q;

	// Decoder state.
	fimw_state_t       state_q;
	fimw_state_t       state_d;
	logic [PEND_W-1:0] pend_q;
	logic [WORD_W-1:0] ws_q;
	logic [WORD_W-1:0] mw_q;
	logic [3:0]        bc_q;
	logic              syn_q;

	// Per-interval sequencing.
	logic [SHIFTS_W-1:0] shifts_q;
	logic [SHIFTS_W-1:0] step_q;

	// Words completed by the current interval, released once it is finished
	// so that the last one can be flagged.
	logic [WORD_W-1:0] wbuf_q [2];
	logic              wsyn_q [2];
	logic [1:0]        wcnt_q;
	logic              rd_q;

	// Output register.
	logic              ov_q;
	logic [WORD_W-1:0] ow_q;
	logic              osyn_q;
	logic              olast_q;

	// Control.
	logic       in_ready;
	logic       q_start;
	logic       step_en;
	logic       drain_load;
	logic       nonzero;
	logic       step_last;
	logic       drain_final;
	logic [1:0] wcnt_next;
	quant_res_t qres;

	// Acceptance arithmetic.
	logic [PEND_W:0]    sum_units;
	logic [PEND_W:0]    sum_over;
	logic [UNITS_W-1:0] units_clamped;

	// One bitcell step.
	logic              cell_bit;
	logic [WORD_W-1:0] ws_a;
	logic [WORD_W-1:0] mw_a;
	logic              hit;
	logic [WORD_W-1:0] ws_b;
	logic [WORD_W-1:0] mw_b;
	logic [3:0]        bc_b;
	logic              syn_b;
	logic              wrap;

	// ---------------------------------------------------------------------
	// Configuration writes
	// ---------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q  <= TOL_RESET;
			sync_q <= SYNC_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_TOL: begin
					tol_q <= cfg_wdata[TOL_W-1:0];
				end
				CFG_SYNC: begin
					sync_q <= cfg_wdata;
				end
				default: begin
				end
			endcase
		end
	end

	// ---------------------------------------------------------------------
	// Interval acceptance: add the pending overflow total, then clamp to the
	// range the quantizer needs. A zero interval only grows the total, with
	// saturation at the top of its 20 bits.
	// ---------------------------------------------------------------------
	assign nonzero       = (flux_in.flux_interval != '0);
	assign sum_units     = 21'(pend_q) + 21'(flux_in.flux_interval);
	assign sum_over      = 21'(pend_q) + 21'(OVERFLOW_UNITS);
	assign units_clamped = (sum_units >= 21'(CLAMP_UNITS)) ? CLAMP_UNITS
		: sum_units[UNITS_W-1:0];

	fimw_quant #(
		.MAX_SHIFTS(MAX_SHIFTS)
	) u_quant (
		.clk              (clk),
		.arst_n           (arst_n),
		.start            (q_start),
		.units            (units_clamped),
		.window_tolerance (tol_q),
		.res              (qres)
	);

	// ---------------------------------------------------------------------
	// Bitcell shifter. Only the final cell of an interval carries a one. If
	// the mark window then equals the sync pattern, the word is pushed up to
	// its top and closed at once; a zero pattern never matches.
	// ---------------------------------------------------------------------
	always_comb begin
		step_last = (step_q == shifts_q - SHIFTS_W'(1));
		cell_bit  = step_last;
		ws_a      = ws_q | WORD_W'(cell_bit);
		mw_a      = mw_q | WORD_W'(cell_bit);
		hit       = (sync_q != '0) && (mw_a == sync_q);
		if (hit) begin
			ws_b  = ws_a << (4'd15 - bc_q);
			mw_b  = '0;
			bc_b  = 4'd15;
			syn_b = 1'b1;
		end else begin
			ws_b  = ws_a;
			mw_b  = mw_a;
			bc_b  = bc_q;
			syn_b = syn_q;
		end
		wrap      = (bc_b == 4'd15);
		wcnt_next = wcnt_q + 2'(wrap);
	end

	assign drain_final = ((2'(rd_q) + 2'd1) == wcnt_q);

	// ---------------------------------------------------------------------
	// Sequencer
	// ---------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		in_ready   = 1'b0;
		q_start    = 1'b0;
		step_en    = 1'b0;
		drain_load = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				q_start  = flux_in.valid && nonzero;
				if (q_start) begin
					state_d = ST_QUANT;
				end
			end
			ST_QUANT: begin
				if (qres.done) begin
					state_d = (qres.shifts == '0) ? ST_IDLE : ST_SHIFT;
				end
			end
			ST_SHIFT: begin
				step_en = 1'b1;
				if (step_last) begin
					state_d = (wcnt_next == 2'd0) ? ST_IDLE : ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (!ov_q || word_out.ready) begin
					drain_load = 1'b1;
					if (drain_final) begin
						state_d = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// ---------------------------------------------------------------------
	// Decoder state registers
	// ---------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
			ws_q   <= '0;
			mw_q   <= '0;
			bc_q   <= '0;
			syn_q  <= 1'b0;
			wcnt_q <= '0;
			rd_q   <= 1'b0;
			step_q <= '0;
		end else begin
			if (in_ready && flux_in.valid) begin
				if (nonzero) begin
					pend_q <= '0;
				end else if (sum_over[PEND_W]) begin
					pend_q <= PENDING_MAX;
				end else begin
					pend_q <= sum_over[PEND_W-1:0];
				end
			end
			if (q_start) begin
				wcnt_q <= '0;
				rd_q   <= 1'b0;
			end
			if (state_q == ST_QUANT && qres.done) begin
				step_q <= '0;
			end
			if (step_en) begin
				step_q <= step_q + SHIFTS_W'(1);
				mw_q   <= mw_b << 1;
				bc_q   <= bc_b + 4'd1;
				if (wrap) begin
					ws_q   <= '0;
					syn_q  <= 1'b0;
					wcnt_q <= wcnt_next;
				end else begin
					ws_q  <= ws_b << 1;
					syn_q <= syn_b;
				end
			end
			if (drain_load) begin
				rd_q <= ~rd_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_QUANT && qres.done) begin
			shifts_q <= qres.shifts;
		end
		if (step_en && wrap && wcnt_q != 2'd2) begin
			wbuf_q[wcnt_q[0]] <= ws_b;
			wsyn_q[wcnt_q[0]] <= syn_b;
		end
	end

	// ---------------------------------------------------------------------
	// Output register: loaded from the word buffer whenever it is empty or
	// being taken; the last buffered word of an interval is flagged.
	// ---------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
		end else if (drain_load) begin
			ov_q <= 1'b1;
		end else if (word_out.ready) begin
			ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (drain_load) begin
			ow_q    <= wbuf_q[rd_q];
			osyn_q  <= wsyn_q[rd_q];
			olast_q <= drain_final;
		end
	end

	assign flux_in.ready       = in_ready;
	assign word_out.valid      = ov_q;
	assign word_out.mfm_word   = ow_q;
	assign word_out.data_byte  = pick_data(ow_q);
	assign word_out.clock_byte = pick_clock(ow_q);
	assign word_out.synced     = osyn_q;
	assign word_out.last       = olast_q;

	// ---------------------------------------------------------------------
	// Checks
	// ---------------------------------------------------------------------
	`FIMW_ASSERT_NEXT(a_start_enters_quant, q_start, state_q == ST_QUANT)
	`FIMW_ASSERT_IMPLY(a_done_while_waiting, qres.done, state_q == ST_QUANT)
	`FIMW_ASSERT_IMPLY(a_drain_has_words, state_q == ST_DRAIN, wcnt_q == 2'd1 || wcnt_q == 2'd2)
	`FIMW_ASSERT_IMPLY(a_buffer_room, step_en && wrap, wcnt_q != 2'd2)

endmodule

// File: verif/flux_interval_to_mfm_word_core_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// flux_interval_to_mfm_word_core_tb
// Self-checking bench for the flux interval to MFM word decoder. Intervals
// are offered through a valid/ready driver. A behavioural decoder in the
// bench predicts every MFM word at acceptance time, and a monitor compares
// each word leaving the block field by field. Traffic is mostly well-formed
// MFM cell runs with address marks, mixed with overflow, short, long and
// off-grid intervals, under several window and sync register settings.
// ---------------------------------------------------------------------------
module flux_interval_to_mfm_word_core_tb import fimw_pkg::*;;

	localparam int MAX_CELLS    = 8;
	localparam int LIMIT_CYCLES = 500000;
	// Longest path through the block is acceptance, the quantizer pipeline and
	// the bitcell steps, then the drain; this margin covers an interval that produces no word at all.
	localparam int SETTLE_CYCLES = 24;
	localparam int HOLD_CYCLES   = 400;

	// One decoded word as it should leave the block.
	typedef struct {
		logic [WORD_W-1:0] word;
		logic [BYTE_W-1:0] data;
		logic [BYTE_W-1:0] clock;
		logic              synced;
		logic              last;
	} mfm_word_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [WORD_W-1:0] cfg_wdata;

	fimw_in_if  flux_ch();
	fimw_out_if word_ch();

	flux_interval_to_mfm_word_core #(
		.MAX_SHIFTS(MAX_CELLS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.flux_in(flux_ch),
		.word_out(word_ch)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Copy of the register file as the block should see it.
	logic [TOL_W-1:0]  tol_cfg  = TOL_RESET;
	logic [WORD_W-1:0] sync_cfg = SYNC_RESET;

	// Decoder state of the behavioural model; all of it starts out cleared.
	int unsigned       pend_units = 0;
	logic [WORD_W-1:0] word_reg   = '0;
	logic [WORD_W-1:0] mark_reg   = '0;
	logic [4:0]        cell_count = '0;
	logic              word_sync  = 1'b0;

	mfm_word_t         words_due[$];
	logic [FLUX_W-1:0] flux_q[$];

	int errors      = 0;
	int items_in    = 0;
	int words_seen  = 0;
	int synced_seen = 0;
	int settings    = 1;
	int cycles      = 0;

	// When set, both sides run without any idle cycles.
	bit steady = 1'b0;
	// Raised by the sequence to ask the receiver for one long hold-off.
	bit hold_req = 1'b0;

	bit in_taken  = 1'b0;
	bit out_taken = 1'b0;

	task automatic report_mismatch(input string msg);
		$display("MISMATCH at cycle %0d: %s", cycles, msg);
		errors++;
	endtask

	// Behavioural decoder: consumes one accepted interval and queues the
	// words it completes, with the last flag on the final one.
	task automatic decode_interval(input logic [FLUX_W-1:0] flux);
		int unsigned total;
		int unsigned even_us;
		int unsigned even_units;
		int unsigned quant_us;
		int          cells;
		int          n_done;
		mfm_word_t   done_words[2];
		mfm_word_t   w;
		n_done = 0;
		// A zero interval only extends the pending total, which saturates.
		if (flux == '0) begin
			pend_units = pend_units + OVERFLOW_UNITS;
			if (pend_units > PENDING_MAX)
				pend_units = PENDING_MAX;
			return;
		end
		total = pend_units + flux;
		pend_units = 0;

		// Nearest even microsecond, then one either side outside the window.
		even_us = ((total / 40) + 1) & ~32'd1;
		even_units = even_us * 40;
		if (total + tol_cfg < even_units)
			quant_us = even_us - 1;
		else if (total > even_units + tol_cfg)
			quant_us = even_us + 1;
		else
			quant_us = even_us;
		cells = quant_us / 2;
		if (cells > MAX_CELLS)
			cells = MAX_CELLS;

		for (int j = 0; j < cells; j++) begin
			// Only the final cell of an interval carries the reversal.
			if (j == cells - 1) begin
				word_reg[0] = 1'b1;
				mark_reg[0] = 1'b1;
			end
			// An address mark pushes the partial word to the top and forces
			// the word to complete on this cell.
			if (sync_cfg != '0 && mark_reg == sync_cfg) begin
				mark_reg = '0;
				word_reg = word_reg << (15 - cell_count[3:0]);
				cell_count = 5'd15;
				word_sync = 1'b1;
			end
			mark_reg = mark_reg << 1;
			cell_count++;
			if (cell_count == 5'd16) begin
				if (n_done < 2) begin
					w.word = word_reg;
					for (int k = 0; k < BYTE_W; k++) begin
						w.data[7-k]  = word_reg[14-2*k];
						w.clock[7-k] = word_reg[15-2*k];
					end
					w.synced = word_sync;
					w.last = 1'b0;
					done_words[n_done] = w;
					n_done++;
				end
				word_reg = '0;
				cell_count = '0;
				word_sync = 1'b0;
			end
			word_reg = word_reg << 1;
		end

		for (int k = 0; k < n_done; k++) begin
			w = done_words[k];
			w.last = (k == n_done - 1);
			words_due.push_back(w);
		end
	endtask

	// Input acceptance: every handshake feeds the decoder model.
	always @(posedge clk) begin
		if (arst_n && flux_ch.valid && flux_ch.ready) begin
			in_taken = 1'b1;
			items_in++;
			decode_interval(flux_ch.flux_interval);
		end
	end

	// Driver: takes items from the pending queue, with a random gap drawn
	// after each accepted item unless the phase runs steady.
	bit                offering = 1'b0;
	int unsigned       send_gap = 0;
	logic [FLUX_W-1:0] cur_flux = '0;

	always @(negedge clk) begin
		if (arst_n) begin
			if (offering && in_taken) begin
				offering = 1'b0;
				send_gap = steady ? 0 : $urandom_range(0, 7);
			end
			in_taken = 1'b0;
			if (!offering && flux_q.size() != 0) begin
				if (send_gap == 0) begin
					offering = 1'b1;
					cur_flux = flux_q.pop_front();
				end else begin
					send_gap--;
				end
			end
			flux_ch.valid <= offering;
			flux_ch.flux_interval <= cur_flux;
		end else begin
			flux_ch.valid <= 1'b0;
			flux_ch.flux_interval <= '0;
		end
	end

	// Receiver: stalls a random number of cycles after each word, and once
	// holds off for a long stretch so that the block backs up into its input.
	int unsigned stall_left = 0;
	int unsigned hold_left  = 0;

	always @(negedge clk) begin
		if (arst_n) begin
			if (out_taken) begin
				out_taken = 1'b0;
				stall_left = steady ? 0 : $urandom_range(0, 7);
			end
			if (hold_req) begin
				hold_req = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left != 0) begin
				hold_left--;
				word_ch.ready <= 1'b0;
			end else if (stall_left != 0) begin
				stall_left--;
				word_ch.ready <= 1'b0;
			end else begin
				word_ch.ready <= 1'b1;
			end
		end else begin
			word_ch.ready <= 1'b0;
		end
	end

	// Monitor: each word leaving the block is checked against the oldest
	// prediction.
	always @(posedge clk) begin
		mfm_word_t want;
		if (arst_n && word_ch.valid && word_ch.ready) begin
			out_taken = 1'b1;
			words_seen++;
			if (word_ch.synced)
				synced_seen++;
			if (words_due.size() == 0) begin
				report_mismatch($sformatf("unexpected word %h", word_ch.mfm_word));
			end else begin
				want = words_due.pop_front();
				if (word_ch.mfm_word !== want.word)
					report_mismatch($sformatf("mfm_word %h, expected %h",
						word_ch.mfm_word, want.word));
				if (word_ch.data_byte !== want.data)
					report_mismatch($sformatf("data_byte %h, expected %h",
						word_ch.data_byte, want.data));
				if (word_ch.clock_byte !== want.clock)
					report_mismatch($sformatf("clock_byte %h, expected %h",
						word_ch.clock_byte, want.clock));
				if (word_ch.synced !== want.synced)
					report_mismatch($sformatf("synced %b, expected %b",
						word_ch.synced, want.synced));
				if (word_ch.last !== want.last)
					report_mismatch($sformatf("last %b, expected %b",
						word_ch.last, want.last));
			end
		end
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT_CYCLES) begin
			$display("Timed out with %0d words still expected.", words_due.size());
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// Queues one interval of n cells, jittered inside the current window so
	// that it still quantizes to exactly n cells.
	task automatic push_cells(input int n);
		int slack;
		int jit;
		slack = (tol_cfg > 39) ? 39 : tol_cfg;
		jit = $urandom_range(0, 2 * slack) - slack;
		flux_q.push_back(FLUX_W'(n * 80 + jit));
	endtask

	// Queues the intervals that write a 16-cell pattern into the window.
	// Zero runs are folded into the interval that ends on the next one.
	task automatic push_mark(input logic [WORD_W-1:0] pattern);
		int run;
		run = 0;
		for (int b = WORD_W - 1; b >= 0; b--) begin
			run++;
			if (pattern[b]) begin
				push_cells(run > MAX_CELLS ? MAX_CELLS : run);
				run = 0;
			end
		end
	endtask

	// Fills the pending queue with about count intervals. Most are MFM data
	// runs followed by address marks; the rest is noise of several kinds.
	task automatic queue_traffic(input int count);
		int pick;
		int len;
		logic [WORD_W-1:0] mark;
		mark = (sync_cfg == '0) ? SYNC_RESET : sync_cfg;
		while (flux_q.size() < count) begin
			pick = $urandom_range(0, 99);
			if (pick < 72) begin
				len = $urandom_range(4, 24);
				repeat (len) begin
					if ($urandom_range(0, 9) < 8)
						push_cells($urandom_range(2, 4));
					else
						push_cells($urandom_range(1, MAX_CELLS));
				end
				repeat ($urandom_range(1, 3))
					push_mark(mark);
			end else if (pick < 82) begin
				flux_q.push_back(FLUX_W'($urandom_range(0, 65535)));
			end else if (pick < 88) begin
				flux_q.push_back(FLUX_W'($urandom_range(1, 119)));
			end else if (pick < 94) begin
				flux_q.push_back(FLUX_W'($urandom_range(41, 800)));
			end else if (pick < 98) begin
				repeat ($urandom_range(1, 3))
					flux_q.push_back('0);
				flux_q.push_back(FLUX_W'($urandom_range(1, 65535)));
			end else begin
				// Long overflow run that saturates the pending total.
				repeat ($urandom_range(17, 19))
					flux_q.push_back('0);
				flux_q.push_back(FLUX_W'($urandom_range(1, 65535)));
			end
		end
	endtask

	// Waits until every interval is taken and every word has come out, then
	// lets the pipeline empty of intervals that produce no word.
	task automatic wait_idle();
		while (flux_q.size() != 0 || offering || words_due.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// Writes both registers on consecutive cycles while the block is idle.
	task automatic set_regs(input logic [WORD_W-1:0] tol_word,
			input logic [WORD_W-1:0] sync_word);
		cfg_we <= 1'b1;
		cfg_index <= CFG_TOL;
		cfg_wdata <= tol_word;
		@(negedge clk);
		cfg_index <= CFG_SYNC;
		cfg_wdata <= sync_word;
		@(negedge clk);
		cfg_we <= 1'b0;
		tol_cfg = tol_word[TOL_W-1:0];
		sync_cfg = sync_word;
		settings++;
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CFG_TOL;
		cfg_wdata = '0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed part under the reset register values.
		flux_q.push_back(16'd1);       // quantizes to zero cells
		flux_q.push_back(16'hFFFF);    // saturates at the cell limit
		flux_q.push_back(16'd160);
		flux_q.push_back(16'd240);
		flux_q.push_back(16'd320);
		flux_q.push_back(16'd40);      // one microsecond, no cells
		flux_q.push_back(16'd71);      // just below the window edge
		flux_q.push_back(16'd72);      // on the lower window edge
		flux_q.push_back(16'd88);      // on the upper window edge
		flux_q.push_back(16'd89);      // just above it
		flux_q.push_back(16'd119);
		flux_q.push_back('0);          // overflow then a short tail
		flux_q.push_back(16'd100);
		flux_q.push_back('0);
		flux_q.push_back('0);
		flux_q.push_back(16'hFFFF);
		push_cells(3);
		push_cells(2);
		push_mark(SYNC_RESET);
		push_cells(4);
		wait_idle();

		// Tight window, default mark.
		set_regs(16'd0, SYNC_RESET);
		queue_traffic(180);
		wait_idle();

		// Widest specified window; the receiver holds off for a long stretch
		// while the driver keeps offering.
		set_regs(16'd40, SYNC_RESET);
		hold_req = 1'b1;
		queue_traffic(180);
		wait_idle();

		// All window bits set, stray upper data bits, mark detection off.
		set_regs({10'($urandom_range(0, 1023)), 6'd63}, 16'h0000);
		queue_traffic(140);
		wait_idle();

		// Random window and a random mark ending on a reversal.
		set_regs(16'($urandom_range(0, 40)), 16'($urandom_range(0, 65535)) | 16'h0001);
		queue_traffic(180);
		wait_idle();

		// A mark of all ones needs sixteen single-cell intervals in a row.
		set_regs(16'd8, 16'hFFFF);
		queue_traffic(120);
		wait_idle();

		// Back to the usual mark with no idle cycles on either side.
		set_regs(16'd20, SYNC_RESET);
		steady = 1'b1;
		queue_traffic(150);
		wait_idle();
		steady = 1'b0;
		queue_traffic(100);
		wait_idle();

		$display("Decoded %0d flux intervals into %0d words over %0d register settings.",
			items_in, words_seen, settings);
		$display("%0d words were completed by an address mark; %0d mismatches.",
			synced_seen, errors);
		if (errors == 0 && words_due.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
